### rtl/core/asse_pkg.sv
// shared types and constants for the swing speed estimator
package asse_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PG,
    ST_AM,
    ST_AD,
    ST_SQ,
    ST_RT,
    ST_MIX,
    ST_OUT,
    ST_GM,
    ST_GD,
    ST_RD,
    ST_RM
  } state_e;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_CAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_UP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DOWN = 3'd4;

  localparam logic [31:0] MIX_LOWER_RST = 32'd13107;
  localparam logic [31:0] MIX_CAP_RST   = 32'd131072;
  localparam logic [31:0] EDGE_RST      = 32'd32768;
  localparam logic [15:0] GAIN_UP_RST   = 16'd4301;
  localparam logic [15:0] GAIN_DOWN_RST = 16'd6144;

  // 9.81 m/s^2 in q16.16
  localparam logic [19:0] G_Q16      = 20'd642908;
  // step divisor 4096000000 = 2^18 * 15625
  localparam logic [31:0] STEP_HALF  = 32'd2048000000;
  localparam int          STEP_SHIFT = 18;
  localparam logic [13:0] STEP_ODD   = 14'd15625;
  localparam logic [16:0] MIX_ONE    = 17'd65536;

endpackage

### rtl/core/asse_unit.sv
// bit-serial multiply, divide and square root unit
module asse_unit #(
  parameter int W = 66
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asse_pkg::unit_ctl_t ctl_i,
  input  logic [W-1:0]        a_i,
  input  logic [W-1:0]        b_i,
  output asse_pkg::unit_sts_t sts_o,
  output logic [W-1:0]        res_o
);

  localparam int CW     = $clog2(W + 1);
  localparam int HALF_W = W / 2;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  asse_pkg::op_e     op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [W:0]        r0_q, r0_d;
  logic [W-1:0]      r1_q, r1_d;
  logic [W-1:0]      r2_q, r2_d;

  logic [W:0]        sub_x, sub_y;
  logic [W+1:0]      diff;
  logic              ge;
  logic [W-1:0]      sum;

  always_comb begin
    if (op_q == asse_pkg::OP_SQRT) begin
      sub_x = {r0_q[W-2:0], r1_q[W-1:W-2]};
      sub_y = {r2_q[W-2:0], 2'b01};
    end else begin
      sub_x = {r0_q[W-1:0], r1_q[W-1]};
      sub_y = {1'b0, r2_q};
    end
    diff = {1'b0, sub_x} - {1'b0, sub_y};
    ge   = ~diff[W+1];
    sum  = r0_q[W-1:0] + r1_q;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    r2_d   = r2_q;
    if (!busy_q) begin
      if (ctl_i.start) begin
        busy_d = 1'b1;
        op_d   = ctl_i.op;
        r0_d   = '0;
        r1_d   = a_i;
        r2_d   = b_i;
        cnt_d  = CW'(W);
        if (ctl_i.op == asse_pkg::OP_SQRT) begin
          r2_d  = '0;
          cnt_d = CW'(HALF_W);
        end
      end
    end else begin
      case (op_q)
        asse_pkg::OP_MUL: begin
          if (r2_q == '0) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            if (r2_q[0]) begin
              r0_d = {1'b0, sum};
            end
            r1_d = {r1_q[W-2:0], 1'b0};
            r2_d = {1'b0, r2_q[W-1:1]};
          end
        end
        asse_pkg::OP_DIV: begin
          r0_d  = ge ? diff[W:0] : sub_x;
          r1_d  = {r1_q[W-2:0], ge};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        asse_pkg::OP_SQRT: begin
          r0_d  = ge ? diff[W:0] : sub_x;
          r1_d  = {r1_q[W-3:0], 2'b00};
          r2_d  = {r2_q[W-2:0], ge};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= asse_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
    r2_q <= r2_d;
  end

  always_comb begin
    case (op_q)
      asse_pkg::OP_MUL:  res_o = r0_q[W-1:0];
      asse_pkg::OP_DIV:  res_o = r1_q;
      asse_pkg::OP_SQRT: res_o = r2_q;
      default:           res_o = '0;
    endcase
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

### rtl/core/accel_swing_speed_estimator_core.sv
// Swing speed estimator: integrates three-axis acceleration into saturating
// velocities, reports speed and mix level, then damps the velocities. Every
// multiply, divide and square root runs one bit per cycle on a single shared
// unit whose width W is the largest of 2*VEL_BITS+2, 96-VEL_BITS, 64 and
// 2*max(ACCEL_BITS,16)+38, rounded up to even (70 at the defaults). The divide
// by the odd part of the step constant is a multiply by its reciprocal. One
// request runs up to four divides, a square root and fifteen multiplies; the
// damping pass is skipped when the speed is zero. The block takes no new
// request until the damping of the previous one is done. The result sits in an
// output register, so damping goes on while the result waits. Config writes are
// always accepted and should only be made while no request is in flight.
module accel_swing_speed_estimator_core #(
  parameter int ACCEL_BITS = 16,
  parameter int VEL_BITS   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ACCEL_BITS-1:0]       accel_x_i,
  input  logic signed [ACCEL_BITS-1:0]       accel_y_i,
  input  logic signed [ACCEL_BITS-1:0]       accel_z_i,
  input  logic [15:0]                        step_us_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        speed_o,
  output logic [16:0]                        mix_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [asse_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int AB  = ACCEL_BITS;
  localparam int VB  = VEL_BITS;
  localparam int F   = 64 - VEL_BITS;
  // dividends of the step divide stay below 2^XB
  localparam int XB  = ((ACCEL_BITS > 16) ? ACCEL_BITS : 16) + 18;
  localparam int RSH = XB + 14;
  localparam int WR  = 2 * XB + 2;
  localparam int WA  = 2 * VEL_BITS + 2;
  localparam int WB  = 96 - VEL_BITS;
  localparam int WM0 = (WA > WB) ? WA : WB;
  localparam int WM1 = (WM0 > 64) ? WM0 : 64;
  localparam int WM  = (WM1 > WR) ? WM1 : WR;
  localparam int W   = WM + (WM % 2);
  localparam int SW  = W + 2;

  localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(asse_pkg::STEP_ODD) - 64'd1) /
                                  64'(asse_pkg::STEP_ODD);

  localparam logic signed [SW-1:0] VMAX_X = signed'({{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}});
  localparam logic signed [SW-1:0] VMIN_X = signed'({{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}});
  localparam logic signed [VB-1:0] VMAX_V = signed'({1'b0, {(VB-1){1'b1}}});
  localparam logic signed [VB-1:0] VMIN_V = signed'({1'b1, {(VB-1){1'b0}}});

  asse_pkg::state_e state_q, state_d;

  logic [1:0]              idx_q;
  logic signed [AB-1:0]    ax_q [3];
  logic [15:0]             us_q;
  logic [W-1:0]            p_q, tmp_q, d_q, sum_q, speed_q;
  logic signed [VB-1:0]    vel_q [3];
  logic                    flag_q;
  logic [16:0]             mix_q;
  logic [31:0]             lower_q, cap_q, edge_q;
  logic [15:0]             gup_q, gdn_q;
  logic                    out_valid_q;
  logic [31:0]             out_speed_q;
  logic [16:0]             out_mix_q;

  asse_pkg::unit_ctl_t     uctl;
  asse_pkg::unit_sts_t     usts;
  logic [W-1:0]            ua, ub, ures;
  logic                    need;
  logic                    done;

  logic signed [AB-1:0]    acur;
  logic [AB-1:0]           amag;
  logic signed [VB-1:0]    vcur;
  logic [VB-1:0]           vmag;
  logic [W-1:0]            step_rnd, step_val, step_quo, del;
  logic [W-1:0]            upd_amt;
  logic                    upd_sub;
  logic signed [SW-1:0]    v_ext, a_ext, vsum;
  logic signed [VB-1:0]    vnew;
  logic                    le_low, ge_cap, gt_edge, flag_new;
  logic                    out_load, last_axis;

  assign done      = usts.done;
  assign last_axis = (idx_q == 2'd2);
  assign out_load  = (state_q == asse_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  // datapath helpers
  always_comb begin
    acur     = ax_q[idx_q];
    amag     = acur[AB-1] ? (~acur + 1'b1) : acur;
    vcur     = vel_q[idx_q];
    vmag     = vcur[VB-1] ? (~vcur + 1'b1) : vcur;
    step_rnd = ures + W'(asse_pkg::STEP_HALF);
    step_val = step_rnd >> asse_pkg::STEP_SHIFT;
    step_quo = ures >> RSH;
    del      = (ures + (W'(1) << (F - 1))) >> F;
    if (state_q == asse_pkg::ST_AD) begin
      upd_amt = step_quo;
      upd_sub = acur[AB-1];
    end else begin
      upd_amt = del;
      upd_sub = ~vcur[VB-1];
    end
    v_ext = signed'({{(SW-VB){vcur[VB-1]}}, vcur});
    a_ext = signed'({2'b00, upd_amt});
    vsum  = upd_sub ? (v_ext - a_ext) : (v_ext + a_ext);
    if (vsum > VMAX_X) begin
      vnew = VMAX_V;
    end else if (vsum < VMIN_X) begin
      vnew = VMIN_V;
    end else begin
      vnew = vsum[VB-1:0];
    end
    le_low  = (ures <= W'(lower_q));
    ge_cap  = (ures >= W'(cap_q));
    gt_edge = (ures > W'(edge_q));
    // set wins over clear
    flag_new = le_low ? 1'b1 : (gt_edge ? 1'b0 : flag_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      asse_pkg::ST_IDLE: if (in_valid_i) state_d = asse_pkg::ST_PG;
      asse_pkg::ST_PG:   if (done) state_d = asse_pkg::ST_AM;
      asse_pkg::ST_AM:   if (done) state_d = asse_pkg::ST_AD;
      asse_pkg::ST_AD: begin
        if (done) state_d = last_axis ? asse_pkg::ST_SQ : asse_pkg::ST_AM;
      end
      asse_pkg::ST_SQ: begin
        if (done && last_axis) state_d = asse_pkg::ST_RT;
      end
      asse_pkg::ST_RT: begin
        if (done) state_d = (le_low || ge_cap) ? asse_pkg::ST_OUT : asse_pkg::ST_MIX;
      end
      asse_pkg::ST_MIX:  if (done) state_d = asse_pkg::ST_OUT;
      asse_pkg::ST_OUT: begin
        if (out_load) state_d = (speed_q == '0) ? asse_pkg::ST_IDLE : asse_pkg::ST_GM;
      end
      asse_pkg::ST_GM:   if (done) state_d = asse_pkg::ST_GD;
      asse_pkg::ST_GD:   if (done) state_d = asse_pkg::ST_RD;
      asse_pkg::ST_RD:   if (done) state_d = asse_pkg::ST_RM;
      asse_pkg::ST_RM: begin
        if (done) state_d = last_axis ? asse_pkg::ST_IDLE : asse_pkg::ST_RD;
      end
      default: state_d = asse_pkg::ST_IDLE;
    endcase
  end

  // unit operands and handshake outputs
  always_comb begin
    need    = 1'b1;
    uctl.op = asse_pkg::OP_MUL;
    ua      = '0;
    ub      = '0;
    case (state_q)
      asse_pkg::ST_PG: begin
        ua = W'(asse_pkg::G_Q16);
        ub = W'(us_q);
      end
      asse_pkg::ST_AM: begin
        ua = p_q;
        ub = W'(amag);
      end
      // divide by the odd part of the step constant through its reciprocal
      asse_pkg::ST_AD, asse_pkg::ST_GD: begin
        ua = W'(RECIP);
        ub = tmp_q;
      end
      asse_pkg::ST_SQ: begin
        ua = W'(vmag);
        ub = W'(vmag);
      end
      asse_pkg::ST_RT: begin
        uctl.op = asse_pkg::OP_SQRT;
        ua      = sum_q;
      end
      asse_pkg::ST_MIX: begin
        uctl.op = asse_pkg::OP_DIV;
        ua      = (speed_q - W'(lower_q)) << 16;
        ub      = W'(cap_q - lower_q);
      end
      asse_pkg::ST_GM: begin
        ua = p_q;
        ub = W'(flag_q ? gup_q : gdn_q);
      end
      asse_pkg::ST_RD: begin
        uctl.op = asse_pkg::OP_DIV;
        ua      = W'(vmag) << F;
        ub      = speed_q;
      end
      asse_pkg::ST_RM: begin
        ua = tmp_q;
        ub = d_q;
      end
      default: need = 1'b0;
    endcase
    uctl.start = need && !usts.busy && !usts.done;
  end

  assign in_ready_o  = (state_q == asse_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign speed_o     = out_speed_q;
  assign mix_o       = out_mix_q;

  asse_unit #(
    .W (W)
  ) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (uctl),
    .a_i    (ua),
    .b_i    (ub),
    .sts_o  (usts),
    .res_o  (ures)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asse_pkg::ST_IDLE;
      idx_q       <= 2'd0;
      vel_q[0]    <= '0;
      vel_q[1]    <= '0;
      vel_q[2]    <= '0;
      flag_q      <= 1'b1;
      out_valid_q <= 1'b0;
      lower_q     <= asse_pkg::MIX_LOWER_RST;
      cap_q       <= asse_pkg::MIX_CAP_RST;
      edge_q      <= asse_pkg::EDGE_RST;
      gup_q       <= asse_pkg::GAIN_UP_RST;
      gdn_q       <= asse_pkg::GAIN_DOWN_RST;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          asse_pkg::CFG_MIX_LOWER: lower_q <= cfg_data_i;
          asse_pkg::CFG_MIX_CAP:   cap_q   <= cfg_data_i;
          asse_pkg::CFG_EDGE:      edge_q  <= cfg_data_i;
          asse_pkg::CFG_GAIN_UP:   gup_q   <= cfg_data_i[15:0];
          asse_pkg::CFG_GAIN_DOWN: gdn_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == asse_pkg::ST_IDLE) begin
        idx_q <= 2'd0;
      end else if (done && (state_q == asse_pkg::ST_AD || state_q == asse_pkg::ST_SQ ||
                            state_q == asse_pkg::ST_RM)) begin
        idx_q <= last_axis ? 2'd0 : idx_q + 2'd1;
      end
      if (done && (state_q == asse_pkg::ST_AD || state_q == asse_pkg::ST_RM)) begin
        vel_q[idx_q] <= vnew;
      end
      if (done && state_q == asse_pkg::ST_RT) begin
        flag_q <= flag_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ax_q[0] <= accel_x_i;
      ax_q[1] <= accel_y_i;
      ax_q[2] <= accel_z_i;
      us_q    <= step_us_i;
      sum_q   <= '0;
    end
    if (done) begin
      case (state_q)
        asse_pkg::ST_PG:  p_q   <= ures;
        asse_pkg::ST_AM:  tmp_q <= step_val;
        asse_pkg::ST_SQ:  sum_q <= sum_q + ures;
        asse_pkg::ST_RT: begin
          speed_q <= ures;
          mix_q   <= le_low ? 17'd0 : asse_pkg::MIX_ONE;
        end
        asse_pkg::ST_MIX: mix_q <= ures[16:0];
        asse_pkg::ST_GM:  tmp_q <= step_val;
        asse_pkg::ST_GD:  d_q   <= step_quo;
        asse_pkg::ST_RD:  tmp_q <= ures;
        default: ;
      endcase
    end
    if (out_load) begin
      out_speed_q <= (speed_q > W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : speed_q[31:0];
      out_mix_q   <= mix_q;
    end
  end

  // a new request only lands on an idle unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !usts.busy)
    else $error("request accepted while unit busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    uctl.start |-> !usts.busy && !usts.done)
    else $error("unit started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mix_o <= asse_pkg::MIX_ONE))
    else $error("mix above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == asse_pkg::ST_PG))
    else $error("accepted request did not start");

endmodule
